// ===== hw/rtl/jht_pkg.sv =====
package jht_pkg;

  localparam int ValW = 20;
  localparam int AngW = 33;

  localparam logic [33:0] TwoPiQ30  = 34'd6746518852;
  localparam logic [33:0] PiQ30     = 34'd3373259426;
  localparam logic [33:0] HalfPiQ30 = 34'd1686629713;
  localparam logic signed [AngW-1:0] GainQ30 = 33'sd652032874;

  localparam logic signed [35:0] ElemMax = 36'sd524287;
  localparam logic signed [35:0] ElemMin = -36'sd524288;

  localparam logic [1:0] LastRow = 2'd3;

  localparam logic REG_AXIS = 1'b0;
  localparam logic REG_KIND = 1'b1;

  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } jht_axis_e;

  typedef enum logic {
    KIND_TRANS = 1'b0,
    KIND_ROT   = 1'b1
  } jht_kind_e;

  typedef struct packed {
    jht_axis_e axis;
    jht_kind_e kind;
  } jht_cfg_t;

  typedef struct packed {
    logic                   vld;
    logic                   neg;
    logic signed [ValW-1:0] val;
    logic signed [AngW-1:0] z;
  } jht_ang_t;

  typedef struct packed {
    logic                   vld;
    logic                   neg;
    logic signed [ValW-1:0] val;
    logic signed [AngW-1:0] x;
    logic signed [AngW-1:0] y;
  } jht_cs_t;

  typedef struct packed {
    logic signed [ValW-1:0] c3;
    logic signed [ValW-1:0] c2;
    logic signed [ValW-1:0] c1;
    logic signed [ValW-1:0] c0;
  } jht_row_t;

  function automatic logic signed [AngW-1:0] atan_q30(input int i);
    unique case (i)
      0:       return 33'sd843314857;
      1:       return 33'sd497837829;
      2:       return 33'sd263043836;
      3:       return 33'sd133525158;
      4:       return 33'sd67021687;
      5:       return 33'sd33543516;
      6:       return 33'sd16775851;
      7:       return 33'sd8388437;
      8:       return 33'sd4194283;
      9:       return 33'sd2097149;
      default: return 33'sd1 <<< (30 - i);
    endcase
  endfunction

  function automatic logic signed [ValW-1:0] sat_elem(input logic signed [35:0] v);
    if (v > ElemMax) begin
      return ElemMax[ValW-1:0];
    end else if (v < ElemMin) begin
      return ElemMin[ValW-1:0];
    end else begin
      return v[ValW-1:0];
    end
  endfunction

endpackage

// ===== hw/rtl/jht_reduce.sv =====
module jht_reduce
  import jht_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   vld_i,
  input  logic signed [ValW-1:0] val_i,
  output jht_ang_t               ang_o
);

  localparam int Sh   = 30 - FRACTION_BITS;
  localparam int MagW = ValW + Sh;
  localparam int RW   = (MagW > 34) ? MagW : 34;
  localparam int NRed = (FRACTION_BITS < 16) ? 17 - FRACTION_BITS : 1;

  logic [NRed:0]          vld_q;
  logic [NRed:0]          sgn_q;
  logic [RW-1:0]          mag_q [NRed+1];
  logic signed [ValW-1:0] val_q [NRed+1];

  logic [ValW-1:0] abs_v;
  logic [RW-1:0]   mag_d;

  logic                   w_vld_q, w_sg_q;
  logic [33:0]            w_m_q;
  logic signed [ValW-1:0] w_val_q;

  logic                   f_vld_q, f_sg_q, f_neg_q;
  logic [33:0]            f_m_q;
  logic signed [ValW-1:0] f_val_q;

  logic [33:0]            m_in;
  logic                   wrap, fold;
  logic signed [AngW-1:0] zp;
  jht_ang_t               ang_q;

  assign abs_v = val_i[ValW-1] ? ValW'(-val_i) : ValW'(val_i);
  assign mag_d = RW'(abs_v) << Sh;

  assign m_in = mag_q[NRed][33:0];
  assign wrap = m_in > PiQ30;
  assign fold = w_m_q > HalfPiQ30;
  assign zp   = signed'(f_m_q[AngW-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      w_vld_q <= 1'b0;
      f_vld_q <= 1'b0;
      ang_q   <= '0;
    end else if (en_i) begin
      vld_q     <= {vld_q[NRed-1:0], vld_i};
      w_vld_q   <= vld_q[NRed];
      f_vld_q   <= w_vld_q;
      ang_q.vld <= f_vld_q;
      ang_q.neg <= f_neg_q;
      ang_q.val <= f_val_q;
      ang_q.z   <= f_sg_q ? -zp : zp;
    end
  end

  // restoring modulo two pi, one quotient bit per stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q[0] <= mag_d;
      sgn_q[0] <= val_i[ValW-1];
      val_q[0] <= val_i;
      for (int j = 1; j <= NRed; j++) begin
        if (mag_q[j-1] >= (RW'(TwoPiQ30) << (NRed - j))) begin
          mag_q[j] <= mag_q[j-1] - (RW'(TwoPiQ30) << (NRed - j));
        end else begin
          mag_q[j] <= mag_q[j-1];
        end
        sgn_q[j] <= sgn_q[j-1];
        val_q[j] <= val_q[j-1];
      end
      w_m_q   <= wrap ? TwoPiQ30 - m_in : m_in;
      w_sg_q  <= sgn_q[NRed] ^ wrap;
      w_val_q <= val_q[NRed];
      f_m_q   <= fold ? PiQ30 - w_m_q : w_m_q;
      f_sg_q  <= w_sg_q ^ fold;
      f_neg_q <= fold;
      f_val_q <= w_val_q;
    end
  end

  assign ang_o = ang_q;

endmodule

// ===== hw/rtl/jht_cordic.sv =====
module jht_cordic
  import jht_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  jht_ang_t ang_i,
  output jht_cs_t  cs_o
);

  localparam int NSt = (CORDIC_STEPS > 31) ? 31 : CORDIC_STEPS;

  logic [NSt-1:0]         vld_q;
  logic [NSt-1:0]         neg_q;
  logic signed [AngW-1:0] x_q [NSt];
  logic signed [AngW-1:0] y_q [NSt];
  logic signed [AngW-1:0] z_q [NSt];
  logic signed [AngW-1:0] xi  [NSt];
  logic signed [AngW-1:0] yi  [NSt];
  logic signed [AngW-1:0] zi  [NSt];
  logic signed [ValW-1:0] val_q [NSt];

  always_comb begin
    xi[0] = GainQ30;
    yi[0] = '0;
    zi[0] = ang_i.z;
    for (int j = 1; j < NSt; j++) begin
      xi[j] = x_q[j-1];
      yi[j] = y_q[j-1];
      zi[j] = z_q[j-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NSt-2:0], ang_i.vld};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q    <= {neg_q[NSt-2:0], ang_i.neg};
      val_q[0] <= ang_i.val;
      for (int j = 0; j < NSt; j++) begin
        if (!zi[j][AngW-1]) begin
          x_q[j] <= xi[j] - (yi[j] >>> j);
          y_q[j] <= yi[j] + (xi[j] >>> j);
          z_q[j] <= zi[j] - atan_q30(j);
        end else begin
          x_q[j] <= xi[j] + (yi[j] >>> j);
          y_q[j] <= yi[j] - (xi[j] >>> j);
          z_q[j] <= zi[j] + atan_q30(j);
        end
      end
      for (int j = 1; j < NSt; j++) begin
        val_q[j] <= val_q[j-1];
      end
    end
  end

  assign cs_o.vld = vld_q[NSt-1];
  assign cs_o.neg = neg_q[NSt-1];
  assign cs_o.val = val_q[NSt-1];
  assign cs_o.x   = x_q[NSt-1];
  assign cs_o.y   = y_q[NSt-1];

endmodule

// ===== hw/rtl/jht_rows.sv =====
module jht_rows
  import jht_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  jht_cs_t                cs_i,
  input  jht_cfg_t               cfg_i,
  input  logic                   out_ready_i,
  output logic                   en_o,
  output logic                   out_valid_o,
  output logic [1:0]             row_index_o,
  output logic signed [ValW-1:0] col0_value_o,
  output logic signed [ValW-1:0] col1_value_o,
  output logic signed [ValW-1:0] col2_value_o,
  output logic signed [ValW-1:0] col3_value_o,
  output logic                   last_row_o
);

  localparam int Sh   = 30 - FRACTION_BITS;
  localparam int RndW = AngW + 2;
  localparam logic signed [RndW-1:0] Half = signed'((35'd1 << Sh) >> 1);
  localparam logic signed [35:0]     One  = 36'sd1 <<< FRACTION_BITS;

  logic signed [AngW:0]   xe, ye;
  logic                   r1_vld_q;
  logic signed [AngW:0]   r1_x_q, r1_y_q;
  logic signed [ValW-1:0] r1_val_q;

  logic                   r2_vld_q;
  logic signed [RndW-1:0] r2_c_q, r2_s_q;
  logic signed [ValW-1:0] r2_val_q;

  logic signed [35:0]     cv, sv, tv;
  logic signed [ValW-1:0] e_one, e_c, e_s, e_ns, e_t;
  jht_row_t               new_rows [4];

  logic                   mat_vld_q;
  logic [1:0]             row_q;
  jht_row_t               rows_q [4];

  assign xe = (AngW+1)'(cs_i.x);
  assign ye = (AngW+1)'(cs_i.y);

  assign en_o = !mat_vld_q || (out_ready_i && row_q == LastRow);

  assign cv = (cfg_i.kind == KIND_ROT) ? 36'(r2_c_q) : One;
  assign sv = (cfg_i.kind == KIND_ROT) ? 36'(r2_s_q) : '0;
  assign tv = (cfg_i.kind == KIND_ROT) ? '0 : 36'(r2_val_q);

  assign e_one = sat_elem(One);
  assign e_c   = sat_elem(cv);
  assign e_s   = sat_elem(sv);
  assign e_ns  = sat_elem(-sv);
  assign e_t   = sat_elem(tv);

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      new_rows[r] = '0;
    end
    new_rows[0].c0 = e_one;
    new_rows[1].c1 = e_one;
    new_rows[2].c2 = e_one;
    new_rows[3].c3 = e_one;
    unique case (cfg_i.axis)
      AXIS_X: begin
        new_rows[0].c3 = e_t;
        new_rows[1].c1 = e_c;
        new_rows[1].c2 = e_ns;
        new_rows[2].c1 = e_s;
        new_rows[2].c2 = e_c;
      end
      AXIS_Y: begin
        new_rows[0].c0 = e_c;
        new_rows[0].c2 = e_s;
        new_rows[1].c3 = e_t;
        new_rows[2].c0 = e_ns;
        new_rows[2].c2 = e_c;
      end
      AXIS_Z: begin
        new_rows[0].c0 = e_c;
        new_rows[0].c1 = e_ns;
        new_rows[1].c0 = e_s;
        new_rows[1].c1 = e_c;
        new_rows[2].c3 = e_t;
      end
      AXIS_NONE: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_vld_q  <= 1'b0;
      r2_vld_q  <= 1'b0;
      mat_vld_q <= 1'b0;
      row_q     <= '0;
    end else if (en_o) begin
      r1_vld_q  <= cs_i.vld;
      r2_vld_q  <= r1_vld_q;
      mat_vld_q <= r2_vld_q;
      row_q     <= '0;
    end else if (out_ready_i) begin
      row_q <= row_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      r1_x_q   <= cs_i.neg ? -xe : xe;
      r1_y_q   <= cs_i.neg ? -ye : ye;
      r1_val_q <= cs_i.val;
      // round half up to the output fraction
      r2_c_q   <= (RndW'(r1_x_q) + Half) >>> Sh;
      r2_s_q   <= (RndW'(r1_y_q) + Half) >>> Sh;
      r2_val_q <= r1_val_q;
      for (int r = 0; r < 4; r++) begin
        rows_q[r] <= new_rows[r];
      end
    end else if (out_ready_i) begin
      for (int r = 0; r < 3; r++) begin
        rows_q[r] <= rows_q[r+1];
      end
    end
  end

  assign out_valid_o  = mat_vld_q;
  assign row_index_o  = row_q;
  assign col0_value_o = rows_q[0].c0;
  assign col1_value_o = rows_q[0].c1;
  assign col2_value_o = rows_q[0].c2;
  assign col3_value_o = rows_q[0].c3;
  assign last_row_o   = row_q == LastRow;

endmodule

// ===== hw/rtl/joint_homogeneous_transform_core.sv =====
// Joint homogeneous transform core.
// Input channel (in_valid_i / in_ready_o): one joint value per word, signed,
// FRACTION_BITS fraction bits. Output channel (out_valid_o / out_ready_i):
// four words per joint, rows 0 to 3 of the 4x4 transform, last_row_o on row 3.
// Config port: cfg_we_i writes cfg_data_i to register cfg_index_i
// (0 axis select, 1 joint kind); write only while the core is empty.
// Path: the input word passes the modulo two pi stages, the wrap and fold
// registers, the CORDIC steps and the rounding and matrix registers.
// Throughput: the row register drains one row per cycle while out_ready_i
// is high; the pipeline takes the next word in the cycle the last row
// leaves, and not before.
// Reset: axis none, rotational joint, pipeline empty.
// Receiver stall: the whole pipeline holds, in_ready_o drops, nothing is lost.
module joint_homogeneous_transform_core
  import jht_pkg::*;
#(
  parameter int FRACTION_BITS = 16,
  parameter int CORDIC_STEPS  = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_index_i,
  input  logic [1:0]             cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic signed [ValW-1:0] joint_value_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [1:0]             row_index_o,
  output logic signed [ValW-1:0] col0_value_o,
  output logic signed [ValW-1:0] col1_value_o,
  output logic signed [ValW-1:0] col2_value_o,
  output logic signed [ValW-1:0] col3_value_o,
  output logic                   last_row_o
);

  jht_cfg_t cfg_q;
  jht_ang_t ang;
  jht_cs_t  cs;
  logic     en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.axis <= AXIS_NONE;
      cfg_q.kind <= KIND_ROT;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_AXIS: cfg_q.axis <= jht_axis_e'(cfg_data_i);
        REG_KIND: cfg_q.kind <= jht_kind_e'(cfg_data_i[0]);
      endcase
    end
  end

  assign in_ready_o = en;

  jht_reduce #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_reduce (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .vld_i (in_valid_i),
    .val_i (joint_value_i),
    .ang_o (ang)
  );

  jht_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .ang_i (ang),
    .cs_o  (cs)
  );

  jht_rows #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_rows (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cs_i        (cs),
    .cfg_i       (cfg_q),
    .out_ready_i (out_ready_i),
    .en_o        (en),
    .out_valid_o (out_valid_o),
    .row_index_o (row_index_o),
    .col0_value_o(col0_value_o),
    .col1_value_o(col1_value_o),
    .col2_value_o(col2_value_o),
    .col3_value_o(col3_value_o),
    .last_row_o  (last_row_o)
  );

  // rows of one matrix leave in order
  a_row_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_row_o) |=>
      (out_valid_o && row_index_o == $past(row_index_o) + 2'd1))
    else $error("row sequence broken");

  // no new word while a matrix is still being sent
  a_hold_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_row_o) |-> !in_ready_o)
    else $error("input taken mid matrix");

  // bottom row is always 0 0 0 one; the zeros and the row index are checked
  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_row_o) |->
      (row_index_o == LastRow && col0_value_o == '0 && col1_value_o == '0 &&
       col2_value_o == '0))
    else $error("bad bottom row");

endmodule
